// ===== rtl/ipv4_lpm_pkg.sv =====
package ipv4_lpm_pkg;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned LEN_W     = 6;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
    } entry_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic scan_skip;
        logic scan_last;
    } dp_status_t;

    function automatic logic [ADDR_W-1:0] net_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len == '0 || len > LEN_MAX)
        begin
            m = '0;
        end
        else
        begin
            m = ~({ADDR_W{1'b1}} >> len);
        end
        return m;
    endfunction

endpackage

// ===== rtl/ipv4_lpm_ctrl.sv =====
module ipv4_lpm_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  ipv4_lpm_pkg::dp_status_t sts,
    output ipv4_lpm_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = sts.scan_skip ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("result issued into an occupied output register");

    a_scan_not_skipped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> !sts.scan_skip)
        else $error("table read while the scan should be skipped");

    a_drain_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> $past(cmd.rd))
        else $error("drain entered without a final read");

endmodule

// ===== rtl/ipv4_lpm_dp.sv =====
module ipv4_lpm_dp #(
    parameter int ENTRIES = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [ipv4_lpm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [ipv4_lpm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  ipv4_lpm_pkg::dp_cmd_t                  cmd,
    output ipv4_lpm_pkg::dp_status_t               sts
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int AW = ipv4_lpm_pkg::ADDR_W;
    localparam int LW = ipv4_lpm_pkg::LEN_W;
    localparam int SW = ipv4_lpm_pkg::STATUS_W;

    ipv4_lpm_pkg::entry_t mem [ENTRIES];

    logic          op_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] pfx_reg;
    logic [LW-1:0] len_reg;

    logic [IW-1:0] idx_reg;
    logic [CW-1:0] count_reg;
    logic          rd_vld_reg;
    ipv4_lpm_pkg::entry_t rd_entry_reg;

    logic          dup_reg;
    logic [LW-1:0] best_len_reg;
    logic [AW-1:0] best_pfx_reg;

    logic          out_vld_reg;
    logic [SW-1:0] out_status_reg;
    logic          out_found_reg;
    logic [AW-1:0] out_pfx_reg;
    logic [LW-1:0] out_len_reg;

    logic          len_bad;
    logic          full;
    logic          hit_dup;
    logic          hit_match;
    logic          commit;
    logic [SW-1:0] status_next;
    logic [AW-1:0] in_addr;
    logic [LW-1:0] in_len;

    assign in_addr = s_axis_tdata[AW-1:0];
    assign in_len  = s_axis_tdata[AW+LW-1:AW];

    assign len_bad = (len_reg == '0) || (len_reg > ipv4_lpm_pkg::LEN_MAX);
    assign full    = (count_reg == CW'(ENTRIES));

    assign hit_dup   = rd_vld_reg && (rd_entry_reg.length == len_reg)
                       && (rd_entry_reg.prefix == pfx_reg);
    assign hit_match = rd_vld_reg && (rd_entry_reg.length > best_len_reg)
                       && ((addr_reg & ipv4_lpm_pkg::net_mask(rd_entry_reg.length))
                           == rd_entry_reg.prefix);

    always_comb
    begin
        status_next = ipv4_lpm_pkg::ST_OK;
        commit      = 1'b0;
        if (op_reg == ipv4_lpm_pkg::OP_INSERT)
        begin
            if (len_bad)
            begin
                status_next = ipv4_lpm_pkg::ST_BAD_LEN;
            end
            else if (!dup_reg)
            begin
                if (full)
                begin
                    status_next = ipv4_lpm_pkg::ST_FULL;
                end
                else
                begin
                    commit = cmd.finish;
                end
            end
        end
    end

    assign sts.out_free  = !out_vld_reg || m_axis_tready;
    assign sts.scan_skip = (count_reg == '0)
                           || ((op_reg == ipv4_lpm_pkg::OP_INSERT) && len_bad);
    assign sts.scan_last = (CW'(idx_reg) == count_reg - CW'(1));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd;
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.rd)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (commit)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.finish)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= s_axis_tuser;
            addr_reg     <= in_addr;
            pfx_reg      <= in_addr & ipv4_lpm_pkg::net_mask(in_len);
            len_reg      <= in_len;
            dup_reg      <= 1'b0;
            best_len_reg <= '0;
            best_pfx_reg <= '0;
        end
        else
        begin
            if (hit_dup)
            begin
                dup_reg <= 1'b1;
            end
            if (hit_match)
            begin
                best_len_reg <= rd_entry_reg.length;
                best_pfx_reg <= rd_entry_reg.prefix;
            end
        end
        if (cmd.rd)
        begin
            rd_entry_reg <= mem[idx_reg];
        end
        if (commit)
        begin
            mem[count_reg[IW-1:0]] <= '{prefix: pfx_reg, length: len_reg};
        end
        if (cmd.finish)
        begin
            out_status_reg <= status_next;
            if (op_reg == ipv4_lpm_pkg::OP_LOOKUP)
            begin
                out_found_reg <= (best_len_reg != '0);
                out_pfx_reg   <= best_pfx_reg;
                out_len_reg   <= best_len_reg;
            end
            else
            begin
                out_found_reg <= 1'b0;
                out_pfx_reg   <= '0;
                out_len_reg   <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'b0, out_len_reg, out_pfx_reg, out_found_reg, out_status_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("entry count beyond table depth");

    a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not advance the entry count");

    a_no_read_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !rd_vld_reg && !cmd.rd)
        else $error("result taken while the scan is still in flight");

endmodule

// ===== rtl/ipv4_longest_prefix_match_core.sv =====
// IPv4 longest-prefix-match table of ENTRIES prefixes. Each input word is an
// insert (tuser 0) or a lookup (tuser 1) and yields exactly one result word.
// Prefixes are stored with host bits cleared in the next free slot and never
// removed; a repeated prefix is accepted without change, a length of 0 or
// above 32 is rejected, and a new prefix on a full table reports full. A
// lookup returns the longest stored prefix covering the address. Both kinds
// scan the stored entries through the single read port of the table memory,
// one entry per cycle, except that an insert with a bad length or any item
// on an empty table skips the scan. A new word is accepted while the
// previous result waits in the output register; an item whose result is
// ready before that register frees holds the input until the receiver takes
// the waiting word.
module ipv4_longest_prefix_match_core #(
    parameter int ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // address[31:0], prefix_length[37:32]
    input  logic        s_axis_tuser,   // operation[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status[1:0], match_found[2],
                                        // match_prefix[34:3], match_length[40:35]
);

    ipv4_lpm_pkg::dp_cmd_t    cmd;
    ipv4_lpm_pkg::dp_status_t sts;

    ipv4_lpm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    ipv4_lpm_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
